// ----- design/mqt_pkg.sv -----
// Shared types and constants of the memory quota tracker.
`default_nettype none
package mqt_pkg;

  localparam int ACTION_W  = 2;
  localparam int PEER_ID_W = 8;
  localparam int TIME_W    = 32;
  localparam int BYTES_W   = 48;
  localparam int TMO_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 48;

  // Request kinds
  localparam logic [ACTION_W-1:0] ACT_HEARTBEAT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_INFO      = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_ALLOC     = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HB_TIMEOUT = 2'd1;

  localparam logic [BYTES_W-1:0] LIMIT_RESET   = 48'h0000_4000_0000;
  localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 8'd10;

  typedef struct packed {
    logic               valid;
    logic [BYTES_W-1:0] bytes;
    logic [TIME_W-1:0]  last_seen;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

// ----- design/mqt_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mqt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- design/memory_quota_tracker_unit.sv -----
// Top level of the memory quota tracker: request sequencer around the peer table RAM.
`default_nettype none
// Memory quota tracker. Each request names a peer by index and carries the
// current time; the peer is registered if unknown and its heartbeat is set to
// now. Info and alloc requests then sweep the peer table, drop every peer
// silent for more than heartbeat_timeout seconds and reclaim its bytes from
// the group total (saturating at zero). An increase is granted only if
// total + delta <= the limit; a decrease is granted whenever the peer index
// is in the table. One request is in work at a time. A heartbeat (or unknown
// action) passes the lookup and then the reply; info adds the sweep, alloc
// the sweep and then the alloc step. ENTRIES is min(PEERS, 256), the
// number of table entries a peer index can reach. A peer index outside the
// table skips the lookup and is never granted. The next request can be
// taken in the cycle after the reply is loaded. The reply register lets a
// new request in while the last reply waits; a finished request holds in its
// last state until that register is free. The sweep is bound by the single
// read and single write port of the peer table, one entry per cycle. After
// reset the table is cleared in a pass over every entry during which no
// request is accepted; configuration writes are taken at any time and are
// meant to happen only while the block is idle.
module memory_quota_tracker_unit #(
  parameter int PEERS = 256
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // request channel
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [mqt_pkg::ACTION_W-1:0]    in_action,
  input  wire logic [mqt_pkg::PEER_ID_W-1:0]   in_peer_id,
  input  wire logic [mqt_pkg::TIME_W-1:0]      in_now_seconds,
  input  wire logic                            in_is_increase,
  input  wire logic [mqt_pkg::BYTES_W-1:0]     in_delta_bytes,
  // reply channel
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [mqt_pkg::ACTION_W-1:0]    out_reply_kind,
  output logic                                 out_granted,
  output logic      [mqt_pkg::BYTES_W-1:0]     out_used_bytes,
  output logic      [mqt_pkg::BYTES_W-1:0]     out_limit_bytes,
  // configuration write channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mqt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [mqt_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Only indexes reachable by an 8-bit peer id need table space.
  localparam int ID_SPAN = 1 << mqt_pkg::PEER_ID_W;
  localparam int ENTRIES = (PEERS < ID_SPAN) ? PEERS : ID_SPAN;
  localparam int IW      = $clog2(ENTRIES);
  localparam int CW      = $clog2(ENTRIES + 1);
  localparam int BW      = mqt_pkg::BYTES_W;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_LOOK  = 6'b000100,
    ST_SWEEP = 6'b001000,
    ST_ALLOC = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          chk_r, chk_nxt;
  logic [IW-1:0] wb_idx_r;

  // Latched request
  logic [mqt_pkg::ACTION_W-1:0]  act_r;
  logic [mqt_pkg::PEER_ID_W-1:0] pid_r;
  logic [mqt_pkg::TIME_W-1:0]    now_r;
  logic                          inc_r;
  logic [BW-1:0]                 delta_r;
  logic                          in_tab_r;

  logic [BW-1:0] req_bytes_r, req_bytes_nxt;
  logic [BW-1:0] total_r, total_nxt;
  logic          granted_r, granted_nxt;

  logic [BW-1:0]               limit_r;
  logic [mqt_pkg::TMO_W-1:0]   timeout_r;

  logic                          out_valid_r;
  logic [mqt_pkg::ACTION_W-1:0]  out_kind_r;
  logic                          out_granted_r;
  logic [BW-1:0]                 out_used_r;
  logic [BW-1:0]                 out_limit_r;

  // Peer table port signals
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [mqt_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [mqt_pkg::ENTRY_W-1:0] ram_rdata;

  mqt_pkg::entry_t rd_ent;
  mqt_pkg::entry_t wr_ent;

  logic                        in_acc;
  logic                        in_table;
  logic                        sweep_act;
  logic                        load_out;
  logic                        rd_more;
  logic [mqt_pkg::TIME_W-1:0]  elapsed;
  logic [BW-1:0]               look_bytes;
  logic [BW:0]                 inc_total;
  logic [BW:0]                 inc_peer;
  logic [BW-1:0]               dec_total;
  logic [BW-1:0]               dec_peer;

  mqt_ram #(
    .WIDTH (mqt_pkg::ENTRY_W),
    .DEPTH (ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_ent    = mqt_pkg::entry_t'(ram_rdata);
  assign ram_wdata = wr_ent;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign in_table  = ({{(32 - mqt_pkg::PEER_ID_W){1'b0}}, in_peer_id} < 32'(ENTRIES));
  assign sweep_act = (act_r == mqt_pkg::ACT_INFO) || (act_r == mqt_pkg::ACT_ALLOC);
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign rd_more   = (cnt_r < CW'(ENTRIES));
  assign elapsed   = now_r - rd_ent.last_seen;

  // Unknown peer starts from zero bytes
  assign look_bytes = rd_ent.valid ? rd_ent.bytes : '0;

  assign inc_total = {1'b0, total_r} + {1'b0, delta_r};
  assign inc_peer  = {1'b0, req_bytes_r} + {1'b0, delta_r};
  assign dec_total = (delta_r < total_r) ? delta_r : total_r;
  assign dec_peer  = (delta_r < req_bytes_r) ? delta_r : req_bytes_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    chk_nxt       = 1'b0;
    total_nxt     = total_r;
    req_bytes_nxt = req_bytes_r;
    granted_nxt   = granted_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    wr_ent        = '0;

    unique case (state_r)
      ST_CLEAR: begin
        // Wipe one entry per cycle after reset
        ram_we    = 1'b1;
        ram_waddr = cnt_r[IW-1:0];
        cnt_nxt   = cnt_r + CW'(1);
        if (cnt_r == CW'(ENTRIES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cnt_nxt     = '0;
        granted_nxt = 1'b0;
        if (in_acc) begin
          if (in_table) begin
            ram_re    = 1'b1;
            ram_raddr = in_peer_id[IW-1:0];
            state_nxt = ST_LOOK;
          end else if ((in_action == mqt_pkg::ACT_INFO) ||
                       (in_action == mqt_pkg::ACT_ALLOC)) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_LOOK: begin
        // Register the requester and stamp its heartbeat
        wr_ent.valid     = 1'b1;
        wr_ent.bytes     = look_bytes;
        wr_ent.last_seen = now_r;
        ram_we           = 1'b1;
        ram_waddr        = pid_r[IW-1:0];
        req_bytes_nxt    = look_bytes;
        cnt_nxt          = '0;
        state_nxt        = sweep_act ? ST_SWEEP : ST_DONE;
      end
      ST_SWEEP: begin
        // Read one entry ahead, check and write back the one read last cycle
        if (rd_more) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
        end
        chk_nxt = rd_more;
        if (chk_r && rd_ent.valid &&
            (elapsed > {{(mqt_pkg::TIME_W - mqt_pkg::TMO_W){1'b0}}, timeout_r})) begin
          wr_ent.valid     = 1'b0;
          wr_ent.bytes     = '0;
          wr_ent.last_seen = rd_ent.last_seen;
          ram_we           = 1'b1;
          ram_waddr        = wb_idx_r;
          total_nxt        = (rd_ent.bytes >= total_r) ? '0 : (total_r - rd_ent.bytes);
        end
        if (!rd_more && chk_r) begin
          state_nxt = ((act_r == mqt_pkg::ACT_ALLOC) && in_tab_r) ? ST_ALLOC : ST_DONE;
        end
      end
      ST_ALLOC: begin
        wr_ent.valid     = 1'b1;
        wr_ent.bytes     = req_bytes_r;
        wr_ent.last_seen = now_r;
        ram_we           = 1'b1;
        ram_waddr        = pid_r[IW-1:0];
        if (inc_r) begin
          if (inc_total <= {1'b0, limit_r}) begin
            total_nxt    = inc_total[BW-1:0];
            wr_ent.bytes = inc_peer[BW] ? {BW{1'b1}} : inc_peer[BW-1:0];
            granted_nxt  = 1'b1;
          end
        end else begin
          total_nxt    = total_r - dec_total;
          wr_ent.bytes = req_bytes_r - dec_peer;
          granted_nxt  = 1'b1;
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      chk_r       <= 1'b0;
      total_r     <= '0;
      granted_r   <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= mqt_pkg::LIMIT_RESET;
      timeout_r   <= mqt_pkg::TIMEOUT_RESET;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      chk_r     <= chk_nxt;
      total_r   <= total_nxt;
      granted_r <= granted_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          mqt_pkg::REG_LIMIT:      limit_r   <= cfg_data;
          mqt_pkg::REG_HB_TIMEOUT: timeout_r <= cfg_data[mqt_pkg::TMO_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_bytes_r <= req_bytes_nxt;
    wb_idx_r    <= cnt_r[IW-1:0];
    if (in_acc) begin
      act_r    <= in_action;
      pid_r    <= in_peer_id;
      now_r    <= in_now_seconds;
      inc_r    <= in_is_increase;
      delta_r  <= in_delta_bytes;
      in_tab_r <= in_table;
    end
    if (load_out) begin
      out_kind_r    <= act_r;
      out_granted_r <= granted_r;
      out_used_r    <= total_r;
      out_limit_r   <= limit_r;
    end
  end

  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_reply_kind  = out_kind_r;
  assign out_granted     = out_granted_r;
  assign out_used_bytes  = out_used_r;
  assign out_limit_bytes = out_limit_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while previous one still in work");

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) && ram_we && ram_re |-> (ram_waddr != ram_raddr))
    else $error("sweep read and write-back hit the same entry");

  a_grant_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_granted || (out_reply_kind == mqt_pkg::ACT_ALLOC)))
    else $error("grant on a non-alloc reply");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ready)
    else $error("request accepted during table clear");

  a_reply_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_used_bytes))
    else $error("pending reply dropped or changed");
`endif

endmodule
`default_nettype wire
